>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the resampler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle implication check failed.");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle implication check failed.");

`endif

>>> src/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// Types and fixed constants of the stereo linear resampler.
// ----------------------------------------------------------------------------
package slr_pkg;

    localparam int MAX_RESULTS   = 64;
    localparam int CNT_BITS      = $clog2(MAX_RESULTS);
    localparam int INT_BITS      = 4;
    localparam int CFG_ADDR_BITS = 1;

    localparam logic [CFG_ADDR_BITS-1:0] REG_TARGET_RATE = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RATE_STEP   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL_L = 4'b0010,
        ST_MUL_R = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

>>> src/slr_if.sv
// ----------------------------------------------------------------------------
// slr_if
// Valid/ready channels for source frames and resampled output frames.
// ----------------------------------------------------------------------------
interface slr_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;

    modport source (output valid, output in_left, output in_right, input ready);
    modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface slr_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic                          last_of_run;

    modport source (output valid, output out_left, output out_right,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_left, input out_right,
                    input last_of_run, output ready);
endinterface

>>> src/slr_interp_unit.sv
// ----------------------------------------------------------------------------
// slr_interp_unit
// Shared interpolation datapath: one registered multiply, then rounding add.
// ----------------------------------------------------------------------------
module slr_interp_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic signed [SAMPLE_BITS-1:0] lo,
    input  logic signed [SAMPLE_BITS-1:0] hi,
    input  logic        [FRAC_BITS-1:0]   frac,
    output logic signed [SAMPLE_BITS-1:0] result
);

    localparam int DiffW = SAMPLE_BITS + 1;
    localparam int ProdW = FRAC_BITS + 1 + DiffW;
    localparam int SumW  = SAMPLE_BITS + FRAC_BITS + 2;

    logic signed [DiffW-1:0] diff;
    logic signed [ProdW-1:0] prod;
    logic signed [ProdW-1:0] prod_reg;
    logic signed [SAMPLE_BITS-1:0] lo_reg;
    logic signed [SumW-1:0]  sum;

    assign diff = DiffW'(hi) - DiffW'(lo);
    assign prod = $signed({1'b0, frac}) * diff;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod;
            lo_reg   <= lo;
        end
    end

    // The rounded value always lies between lo and hi, so truncation is exact.
    assign sum = (SumW'(lo_reg) <<< FRAC_BITS) + SumW'(prod_reg)
                 + (SumW'(1) <<< (FRAC_BITS - 1));
    assign result = sum[FRAC_BITS +: SAMPLE_BITS];

endmodule

>>> src/stereo_linear_resampler.sv
// A source frame transfer holds off new input until the block has emitted its n frames (0..64).
// Each output frame passes MUL_L, MUL_R and EMIT; EMIT waits while the output is stalled.
// The single shared multiplier serves left, right, then the rounding step in those states.
// An input that emits no frame leaves the block ready again on the next cycle.
// Reset clears the window to zero, the position to 2.0, rate and target to 1.0, step to 0.
// ----------------------------------------------------------------------------
// stereo_linear_resampler
// Linear-interpolation sample rate converter for stereo PCM with rate ramping.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_linear_resampler #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [slr_pkg::CFG_ADDR_BITS-1:0]         cfg_addr,
    input  logic [FRAC_BITS+slr_pkg::INT_BITS-1:0]    cfg_data,
    slr_in_if.sink                                    in_ch,
    slr_out_if.source                                 out_ch
);

    localparam int PosW = FRAC_BITS + slr_pkg::INT_BITS;
    localparam logic [PosW-1:0] One      = PosW'(1) << FRAC_BITS;
    localparam logic [PosW-1:0] RateMin  = One >> 6;
    localparam logic [PosW-1:0] RateMax  = One << 3;
    localparam logic [PosW-1:0] PosReset = One << 1;
    localparam logic [slr_pkg::CNT_BITS-1:0] CntLast =
        slr_pkg::CNT_BITS'(slr_pkg::MAX_RESULTS - 1);

    slr_pkg::state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] lower_left_reg, lower_right_reg;
    logic signed [SAMPLE_BITS-1:0] upper_left_reg, upper_right_reg;
    logic signed [SAMPLE_BITS-1:0] left_hold_reg;
    logic [PosW-1:0]               pos_reg, pos_next;
    logic [PosW-1:0]               rate_reg, rate_next;
    logic [PosW-1:0]               target_reg, step_reg;
    logic [slr_pkg::CNT_BITS-1:0]  cnt_reg, cnt_next;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_left_reg, out_right_reg;
    logic                          out_last_reg;

    logic                          in_xfer;
    logic                          emit_load;
    logic                          last;
    logic [PosW-1:0]               pos_dec;
    logic [PosW-1:0]               pos_sum;
    logic [PosW-1:0]               tgt;
    logic                          unit_load;
    logic signed [SAMPLE_BITS-1:0] unit_lo, unit_hi, unit_result;

    assign in_ch.ready        = (state_reg == slr_pkg::ST_IDLE);
    assign in_xfer            = in_ch.valid && in_ch.ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_left    = out_left_reg;
    assign out_ch.out_right   = out_right_reg;
    assign out_ch.last_of_run = out_last_reg;

    assign emit_load = (state_reg == slr_pkg::ST_EMIT) && (!out_valid_reg || out_ch.ready);
    assign pos_dec   = (pos_reg >= One) ? (pos_reg - One) : '0;
    assign pos_sum   = pos_reg + rate_reg;
    assign last      = (pos_sum >= One) || (cnt_reg == CntLast);
    assign tgt       = (target_reg < RateMin) ? RateMin :
                       (target_reg > RateMax) ? RateMax : target_reg;

    assign unit_load = (state_reg == slr_pkg::ST_MUL_L) || (state_reg == slr_pkg::ST_MUL_R);
    assign unit_lo   = (state_reg == slr_pkg::ST_MUL_R) ? lower_right_reg : lower_left_reg;
    assign unit_hi   = (state_reg == slr_pkg::ST_MUL_R) ? upper_right_reg : upper_left_reg;

    slr_interp_unit #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_interp (
        .clk    (clk),
        .load   (unit_load),
        .lo     (unit_lo),
        .hi     (unit_hi),
        .frac   (pos_reg[FRAC_BITS-1:0]),
        .result (unit_result)
    );

    always_comb
    begin
        if (step_reg == '0)
        begin
            rate_next = tgt;
        end
        else if (rate_reg < tgt)
        begin
            rate_next = ((tgt - rate_reg) <= step_reg) ? tgt : (rate_reg + step_reg);
        end
        else if (rate_reg > tgt)
        begin
            rate_next = ((rate_reg - tgt) <= step_reg) ? tgt : (rate_reg - step_reg);
        end
        else
        begin
            rate_next = rate_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            slr_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    pos_next = pos_dec;
                    cnt_next = '0;
                    if (pos_dec < One)
                    begin
                        state_next = slr_pkg::ST_MUL_L;
                    end
                end
            end
            slr_pkg::ST_MUL_L:
            begin
                state_next = slr_pkg::ST_MUL_R;
            end
            slr_pkg::ST_MUL_R:
            begin
                state_next = slr_pkg::ST_EMIT;
            end
            slr_pkg::ST_EMIT:
            begin
                if (emit_load)
                begin
                    pos_next   = pos_sum;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = last ? slr_pkg::ST_IDLE : slr_pkg::ST_MUL_L;
                end
            end
            default:
            begin
                state_next = slr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= slr_pkg::ST_IDLE;
            pos_reg         <= PosReset;
            rate_reg        <= One;
            target_reg      <= One;
            step_reg        <= '0;
            cnt_reg         <= '0;
            lower_left_reg  <= '0;
            lower_right_reg <= '0;
            upper_left_reg  <= '0;
            upper_right_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;

            if (cfg_we)
            begin
                case (cfg_addr)
                    slr_pkg::REG_TARGET_RATE: target_reg <= cfg_data;
                    slr_pkg::REG_RATE_STEP:   step_reg   <= cfg_data;
                    default:                  step_reg   <= step_reg;
                endcase
            end

            if (in_xfer)
            begin
                lower_left_reg  <= upper_left_reg;
                lower_right_reg <= upper_right_reg;
                upper_left_reg  <= in_ch.in_left;
                upper_right_reg <= in_ch.in_right;
            end

            if (emit_load)
            begin
                rate_reg      <= rate_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == slr_pkg::ST_MUL_R)
        begin
            left_hold_reg <= unit_result;
        end
        if (emit_load)
        begin
            out_left_reg  <= left_hold_reg;
            out_right_reg <= unit_result;
            out_last_reg  <= last;
        end
    end

    `ASSERT_IMPL(a_rate_in_range, clk, rst_n, 1'b1, (rate_reg >= RateMin) && (rate_reg <= RateMax))
    `ASSERT_IMPL(a_idle_pos_whole, clk, rst_n, state_reg == slr_pkg::ST_IDLE, pos_reg >= One)
    `ASSERT_NEXT(a_last_ends_run, clk, rst_n, emit_load && last, (state_reg == slr_pkg::ST_IDLE) && out_valid_reg && out_last_reg)

endmodule

>>> bench/tb_stereo_linear_resampler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_linear_resampler
// Self-checking bench for the stereo linear resampler. A directed table of
// source frames and register writes comes first, then randomized phases with
// fresh rate settings. Every output transfer is compared with a behavioral
// model or echo-row table values; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_stereo_linear_resampler;

    localparam int INT_BITS      = slr_pkg::INT_BITS;
    localparam int MAX_RESULTS   = slr_pkg::MAX_RESULTS;
    localparam int CFG_ADDR_BITS = slr_pkg::CFG_ADDR_BITS;
    localparam logic [CFG_ADDR_BITS-1:0] REG_TARGET_RATE = slr_pkg::REG_TARGET_RATE;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RATE_STEP   = slr_pkg::REG_RATE_STEP;

    localparam int SAMPLE_BITS   = 16;
    localparam int FRAC_BITS     = 16;
    localparam int RATE_BITS     = FRAC_BITS + INT_BITS;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 200;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_FRAMES  = 26;
    localparam int MAX_PRINTED   = 50;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [RATE_BITS-1:0] rate_t;

    localparam rate_t ONE_POS    = rate_t'(1) << FRAC_BITS;
    localparam rate_t RATE_MIN   = ONE_POS >> 6;
    localparam rate_t RATE_MAX   = ONE_POS << 3;
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    last;
    } out_frame_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_PREDICT, ROW_SILENT, ROW_ECHO} row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_ADDR_BITS-1:0] addr;
        rate_t                    data;
        sample_t                  left;
        sample_t                  right;
        sample_t                  want_left;
        sample_t                  want_right;
    } stim_row_t;

    localparam stim_row_t DIR_ROWS [26] = '{
        '{ROW_SILENT,  REG_TARGET_RATE, 20'h00000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000},
        '{ROW_ECHO,    REG_TARGET_RATE, 20'h00000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000},
        '{ROW_ECHO,    REG_TARGET_RATE, 20'h00000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF},
        '{ROW_ECHO,    REG_TARGET_RATE, 20'h00000, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000},
        '{ROW_ECHO,    REG_TARGET_RATE, 20'h00000, 16'h5555, 16'hAAAA, 16'hFFFF, 16'h0001},
        '{ROW_ECHO,    REG_TARGET_RATE, 20'h00000, 16'h7FFF, 16'h7FFF, 16'h5555, 16'hAAAA},
        '{ROW_WRITE,   REG_TARGET_RATE, 20'h08000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{ROW_PREDICT, REG_TARGET_RATE, 20'h00000, 16'h8000, 16'h8000, 16'h0000, 16'h0000},
        '{ROW_PREDICT, REG_TARGET_RATE, 20'h00000, 16'h7FFF, 16'h0001, 16'h0000, 16'h0000},
        '{ROW_WRITE,   REG_TARGET_RATE, 20'h00400, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{ROW_PREDICT, REG_TARGET_RATE, 20'h00000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000},
        '{ROW_PREDICT, REG_TARGET_RATE, 20'h00000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000},
        '{ROW_WRITE,   REG_TARGET_RATE, 20'h00000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{ROW_PREDICT, REG_TARGET_RATE, 20'h00000, 16'h1234, 16'hEDCB, 16'h0000, 16'h0000},
        '{ROW_WRITE,   REG_TARGET_RATE, 20'hFFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{ROW_PREDICT, REG_TARGET_RATE, 20'h00000, 16'h0F0F, 16'hF0F0, 16'h0000, 16'h0000},
        '{ROW_PREDICT, REG_TARGET_RATE, 20'h00000, 16'h8001, 16'h7FFE, 16'h0000, 16'h0000},
        '{ROW_PREDICT, REG_TARGET_RATE, 20'h00000, 16'h4000, 16'hC000, 16'h0000, 16'h0000},
        '{ROW_WRITE,   REG_RATE_STEP,   20'h00100, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{ROW_WRITE,   REG_TARGET_RATE, 20'h10000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{ROW_PREDICT, REG_TARGET_RATE, 20'h00000, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000},
        '{ROW_PREDICT, REG_TARGET_RATE, 20'h00000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000},
        '{ROW_WRITE,   REG_RATE_STEP,   20'hFFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{ROW_WRITE,   REG_TARGET_RATE, 20'h80000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{ROW_PREDICT, REG_TARGET_RATE, 20'h00000, 16'h3C3C, 16'hC3C3, 16'h0000, 16'h0000},
        '{ROW_PREDICT, REG_TARGET_RATE, 20'h00000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000}
    };

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = REG_TARGET_RATE;
    rate_t                    cfg_data = '0;
    logic                     sink_ready = 1'b0;

    slr_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) src_bus ();
    slr_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) dst_bus ();

    assign dst_bus.ready = sink_ready;

    stereo_linear_resampler #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data),
        .in_ch   (src_bus),
        .out_ch  (dst_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    sample_t    win_lo_l = '0;
    sample_t    win_lo_r = '0;
    sample_t    win_hi_l = '0;
    sample_t    win_hi_r = '0;
    rate_t      read_pos = ONE_POS << 1;
    rate_t      cur_rate = ONE_POS;
    rate_t      target_reg = ONE_POS;
    rate_t      step_reg = '0;
    out_frame_t pending_frames[$];

    int errors = 0;
    int frames_sent = 0;
    int frames_checked = 0;
    int silent_inputs = 0;
    int full_runs = 0;
    int sink_hold = 0;
    int stall_cycles = 0;
    bit steady = 1'b0;

    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic sample_t lerp(sample_t lo, sample_t hi, rate_t frac);
        longint acc;
        acc = longint'(lo) * (longint'(1) << FRAC_BITS)
            + longint'(frac) * (longint'(hi) - longint'(lo))
            + (longint'(1) << (FRAC_BITS - 1));
        acc = acc >>> FRAC_BITS;
        return acc[SAMPLE_BITS-1:0];
    endfunction

    function automatic rate_t next_rate(rate_t rate, rate_t tgt);
        if (step_reg == '0)
            return tgt;
        if (rate < tgt)
            return (tgt - rate <= step_reg) ? tgt : rate + step_reg;
        if (rate > tgt)
            return (rate - tgt <= step_reg) ? tgt : rate - step_reg;
        return rate;
    endfunction

    task automatic predict_input(sample_t l, sample_t r, bit queue_it);
        rate_t      tgt;
        out_frame_t run[$];
        out_frame_t f;
        tgt = (target_reg < RATE_MIN) ? RATE_MIN :
              (target_reg > RATE_MAX) ? RATE_MAX : target_reg;
        win_lo_l = win_hi_l;
        win_lo_r = win_hi_r;
        win_hi_l = l;
        win_hi_r = r;
        read_pos = (read_pos >= ONE_POS) ? read_pos - ONE_POS : '0;
        while (read_pos < ONE_POS && run.size() < MAX_RESULTS)
        begin
            f.left  = lerp(win_lo_l, win_hi_l, read_pos);
            f.right = lerp(win_lo_r, win_hi_r, read_pos);
            f.last  = 1'b0;
            run.push_back(f);
            read_pos = read_pos + cur_rate;
            cur_rate = next_rate(cur_rate, tgt);
        end
        if (run.size() == 0)
            silent_inputs++;
        else
            run[run.size()-1].last = 1'b1;
        if (run.size() == MAX_RESULTS)
            full_runs++;
        if (queue_it)
            foreach (run[i])
                pending_frames.push_back(run[i]);
    endtask

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_output(sample_t l, sample_t r, logic last);
        out_frame_t want;
        frames_checked++;
        if (pending_frames.size() == 0)
        begin
            report_mismatch($sformatf("output frame %0d (%h/%h) arrived with none pending",
                                      frames_checked, l, r));
        end
        else
        begin
            want = pending_frames.pop_front();
            if (l !== want.left)
                report_mismatch($sformatf("output frame %0d left %h, want %h",
                                          frames_checked, l, want.left));
            if (r !== want.right)
                report_mismatch($sformatf("output frame %0d right %h, want %h",
                                          frames_checked, r, want.right));
            if (last !== want.last)
                report_mismatch($sformatf("output frame %0d last_of_run %b, want %b",
                                          frames_checked, last, want.last));
        end
    endtask

    task automatic send_input(sample_t l, sample_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            src_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_bus.valid    <= 1'b1;
        src_bus.in_left  <= l;
        src_bus.in_right <= r;
        @(posedge clk);
        while (!src_bus.ready) @(posedge clk);
        frames_sent++;
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, rate_t data);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        if (addr == REG_TARGET_RATE)
            target_reg = data;
        else
            step_reg = data;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        src_bus.valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && dst_bus.valid && sink_ready)
            check_output(dst_bus.out_left, dst_bus.out_right, dst_bus.last_of_run);
        if (sink_hold > 0)
        begin
            sink_hold--;
        end
        else if (sink_ready)
        begin
            sink_hold = pick_gap();
            if (sink_hold > 0)
                sink_ready <= 1'b0;
        end
        else
        begin
            sink_ready <= 1'b1;
            sink_hold = $urandom_range(0, 12);
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((src_bus.valid && src_bus.ready) || (dst_bus.valid && sink_ready) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: %0d cycles without a transfer", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rate_t   tgt_val;
        rate_t   step_val;
        sample_t l;
        sample_t r;

        src_bus.valid    <= 1'b0;
        src_bus.in_left  <= '0;
        src_bus.in_right <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[i])
        begin
            if (DIR_ROWS[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(DIR_ROWS[i].addr, DIR_ROWS[i].data);
            end
            else
            begin
                send_input(DIR_ROWS[i].left, DIR_ROWS[i].right);
                predict_input(DIR_ROWS[i].left, DIR_ROWS[i].right,
                              DIR_ROWS[i].kind == ROW_PREDICT);
                if (DIR_ROWS[i].kind == ROW_ECHO)
                    pending_frames.push_back(out_frame_t'{left: DIR_ROWS[i].want_left,
                                                          right: DIR_ROWS[i].want_right,
                                                          last: 1'b1});
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: tgt_val = RATE_MIN;
                1: tgt_val = RATE_MAX;
                2: tgt_val = rate_t'($urandom_range(0, RATE_MIN - 1));
                3: tgt_val = rate_t'($urandom_range(RATE_MAX + 1, (1 << RATE_BITS) - 1));
                4, 5: tgt_val = rate_t'($urandom_range(ONE_POS / 2, ONE_POS * 2));
                default: tgt_val = rate_t'($urandom_range(RATE_MIN, RATE_MAX));
            endcase
            case ($urandom_range(0, 5))
                0, 1: step_val = '0;
                2: step_val = rate_t'($urandom_range(1, 255));
                3: step_val = rate_t'($urandom_range(256, ONE_POS));
                4: step_val = RATE_MAX;
                default: step_val = rate_t'($urandom);
            endcase
            write_reg(REG_TARGET_RATE, tgt_val);
            write_reg(REG_RATE_STEP, step_val);
            repeat (PHASE_FRAMES)
            begin
                l = pick_sample();
                r = pick_sample();
                send_input(l, r);
                predict_input(l, r, 1'b1);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d source frames in, %0d output frames checked, %0d mismatches",
                 frames_sent, frames_checked, errors);
        $display("summary: %0d inputs emitted nothing, %0d emitted a full run of %0d frames",
                 silent_inputs, full_runs, MAX_RESULTS);
        if (errors == 0 && pending_frames.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
